FILE: hw/rtl/pwmhtc_pkg.sv
// shared types and constants for the pwm high-time capture block
package pwmhtc_pkg;

  localparam int TICK_WIDTH_DEF = 32;
  localparam int REG_WIDTH      = 32;
  localparam int ADDR_WIDTH     = 4;

  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_TIMEOUT     = 2'd1,
    REG_INTERVAL    = 2'd2,
    REG_FIRST_START = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_LOW  = 2'd1,
    PH_WAIT_HIGH = 2'd2,
    PH_WAIT_FALL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OUT_MEASURED          = 2'd0,
    OUT_TIMEOUT_NEVER_LOW = 2'd1,
    OUT_TIMEOUT_AFTER_LOW = 2'd2
  } outcome_t;

  typedef struct packed {
    logic                 enable;
    logic [REG_WIDTH-1:0] timeout_ticks;
    logic [REG_WIDTH-1:0] report_interval;
    logic [REG_WIDTH-1:0] first_start_tick;
  } cfg_t;

  typedef struct packed {
    logic                 enable_wr;
    logic                 first_start_wr;
    logic                 wr_enable_val;
    logic [REG_WIDTH-1:0] wr_data;
  } cfg_evt_t;

endpackage

FILE: hw/rtl/pwmhtc_regs.sv
// apb register file for the pwm high-time capture block
module pwmhtc_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwmhtc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [pwmhtc_pkg::REG_WIDTH-1:0]   pwdata,
  output logic [pwmhtc_pkg::REG_WIDTH-1:0]   prdata,
  output logic                               pready,
  output pwmhtc_pkg::cfg_t                   cfg,
  output pwmhtc_pkg::cfg_evt_t               evt
);
  import pwmhtc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_ENABLE:      cfg.enable           <= pwdata[0];
        REG_TIMEOUT:     cfg.timeout_ticks    <= pwdata;
        REG_INTERVAL:    cfg.report_interval  <= pwdata;
        REG_FIRST_START: cfg.first_start_tick <= pwdata;
        default: ;
      endcase
    end
  end

  // side effects on the measurement state go to the core as one-cycle strobes
  always_comb begin
    evt                = '0;
    evt.wr_data        = pwdata;
    evt.wr_enable_val  = pwdata[0];
    evt.enable_wr      = wr && (idx == REG_ENABLE);
    evt.first_start_wr = wr && (idx == REG_FIRST_START);
  end

  always_comb begin
    case (idx)
      REG_ENABLE:      prdata = {{(REG_WIDTH-1){1'b0}}, cfg.enable};
      REG_TIMEOUT:     prdata = cfg.timeout_ticks;
      REG_INTERVAL:    prdata = cfg.report_interval;
      REG_FIRST_START: prdata = cfg.first_start_tick;
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/pwm_high_time_capture.sv
// pwm input high-time capture: tick counter, window sequencer and result register
// Usage:
//   Each beat on the in channel (in_valid/in_ready, pin_level) is one sampled
//   tick of the pin. A free-running tick counter advances once per beat.
//   Once enable is set and first_start_tick is reached, a window opens that
//   waits for low, then high, then low, and reports the high time on the
//   out channel (out_valid/out_ready, high_time, outcome). If the window
//   deadline passes first, the timeout value (never low) or zero is reported.
//   The next window opens report_interval ticks after each report.
//   Registers sit on the apb port at 0x0 enable, 0x4 timeout_ticks,
//   0x8 report_interval, 0xc first_start_tick; write them while idle.
//   An accepted beat is held in the input stage, then evaluated, and its
//   result lands in the output register, which raises out_valid. The block
//   takes one beat per cycle while the receiver does not stall, set by the single
//   pass of compare/add logic between the input stage and the result register.
//   When the receiver stalls, the held result and one staged beat are kept
//   and in_ready drops; nothing is lost. Reset clears the counter, the config
//   registers and both valid flags, and returns to idle.
module pwm_high_time_capture #(
  parameter int TICK_WIDTH = pwmhtc_pkg::TICK_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwmhtc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [pwmhtc_pkg::REG_WIDTH-1:0]   pwdata,
  output logic [pwmhtc_pkg::REG_WIDTH-1:0]   prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               pin_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        high_time,
  output logic [1:0]                         outcome
);
  import pwmhtc_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;

  pwmhtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  // input stage
  logic stage_valid;
  logic stage_pin;
  logic advance;
  logic step;

  assign advance  = !out_valid || out_ready;
  assign step     = stage_valid && advance;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_pin <= pin_level;
    end
  end

  // measurement state
  phase_t                phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_now, tick_now_next;
  logic [TICK_WIDTH-1:0] next_start, next_start_next;
  logic [TICK_WIDTH-1:0] deadline, deadline_next;
  logic [TICK_WIDTH-1:0] rise_tick, rise_tick_next;

  logic [TICK_WIDTH-1:0] timeout_tw;
  logic [TICK_WIDTH-1:0] start_diff;
  logic [TICK_WIDTH-1:0] dl_diff;
  logic [TICK_WIDTH-1:0] high_diff;
  logic                  start_hit;
  logic                  late;
  logic                  done;
  phase_t                cur_phase;
  logic [31:0]           res_value;
  outcome_t              res_code;

  always_comb begin
    timeout_tw      = TICK_WIDTH'(cfg.timeout_ticks);
    start_diff      = tick_now - next_start;
    high_diff       = tick_now - rise_tick;
    start_hit       = (phase == PH_IDLE) && cfg.enable && !start_diff[TICK_WIDTH-1];
    // on the opening tick the deadline difference is the timeout itself
    dl_diff         = start_hit ? timeout_tw : (deadline - tick_now);
    late            = dl_diff[TICK_WIDTH-1];
    cur_phase       = start_hit ? PH_WAIT_LOW : phase;

    phase_next      = phase;
    tick_now_next   = tick_now;
    next_start_next = next_start;
    deadline_next   = deadline;
    rise_tick_next  = rise_tick;
    done            = 1'b0;
    res_value       = '0;
    res_code        = OUT_MEASURED;

    if (step) begin
      tick_now_next = tick_now + TICK_WIDTH'(1);
      if (start_hit) begin
        deadline_next = tick_now + timeout_tw;
      end
      phase_next = cur_phase;
      case (cur_phase)
        PH_WAIT_LOW: begin
          if (!stage_pin) phase_next = PH_WAIT_HIGH;
        end
        PH_WAIT_HIGH: begin
          if (stage_pin) begin
            rise_tick_next = tick_now;
            phase_next     = PH_WAIT_FALL;
          end
        end
        PH_WAIT_FALL: begin
          if (!stage_pin) begin
            done      = 1'b1;
            res_value = 32'(high_diff);
            res_code  = OUT_MEASURED;
          end
        end
        default: ;
      endcase
      // a falling edge wins over the deadline
      if (cur_phase != PH_IDLE && !done && late) begin
        done = 1'b1;
        if (phase_next == PH_WAIT_LOW) begin
          res_value = cfg.timeout_ticks;
          res_code  = OUT_TIMEOUT_NEVER_LOW;
        end else begin
          res_value = '0;
          res_code  = OUT_TIMEOUT_AFTER_LOW;
        end
      end
      if (done) begin
        next_start_next = tick_now + TICK_WIDTH'(cfg.report_interval);
        phase_next      = PH_IDLE;
      end
    end

    if (evt.enable_wr && !evt.wr_enable_val) begin
      phase_next = PH_IDLE;
    end
    if (evt.first_start_wr) begin
      next_start_next = TICK_WIDTH'(evt.wr_data);
      phase_next      = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_now   <= '0;
      next_start <= '0;
      deadline   <= '0;
      rise_tick  <= '0;
    end else begin
      phase      <= phase_next;
      tick_now   <= tick_now_next;
      next_start <= next_start_next;
      deadline   <= deadline_next;
      rise_tick  <= rise_tick_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && done) begin
      high_time <= res_value;
      outcome   <= res_code;
    end
  end

endmodule

FILE: dv/pwm_capture_checker.sv
// checker for the pwm high-time capture block: predicts reports and checks the out channel
`timescale 1ns / 100ps
module pwm_capture_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [pwmhtc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [pwmhtc_pkg::REG_WIDTH-1:0]  pwdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              pin_level,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [31:0]                       high_time,
  input  logic [1:0]                        outcome,
  output int                                errors,
  output int                                pending
);
  import pwmhtc_pkg::*;

  localparam int TW = TICK_WIDTH_DEF;

  typedef struct packed {
    logic [31:0] high_time;
    outcome_t    outcome;
  } report_t;

  report_t reports_due[$];

  logic          en;
  logic [31:0]   timeout_ticks;
  logic [31:0]   report_interval;
  logic [TW-1:0] tick_now;
  logic [TW-1:0] next_start;
  logic [TW-1:0] deadline;
  logic [TW-1:0] rise_tick;
  phase_t        phase;

  // wrapped tick difference read as two's complement
  function automatic logic is_behind(input logic [TW-1:0] diff);
    return diff[TW-1];
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic apply_reg_write(input reg_idx_t idx, input logic [31:0] val);
    case (idx)
      REG_ENABLE: begin
        en = val[0];
        if (!val[0]) phase = PH_IDLE;
      end
      REG_TIMEOUT:  timeout_ticks = val;
      REG_INTERVAL: report_interval = val;
      REG_FIRST_START: begin
        // reload aborts any open window without a report
        next_start = TW'(val);
        phase = PH_IDLE;
      end
      default: ;
    endcase
  endtask

  // one pin beat = one tick of the window sequencer
  task automatic capture_tick(input logic pin);
    logic [TW-1:0] t;
    logic [31:0]   val;
    outcome_t      oc;
    logic          fire;
    report_t       rep;
    t = tick_now;
    val = '0;
    oc = OUT_MEASURED;
    fire = 1'b0;
    if (phase == PH_IDLE && en && !is_behind(t - next_start)) begin
      deadline = t + timeout_ticks;
      phase = PH_WAIT_LOW;
    end
    if (phase != PH_IDLE) begin
      case (phase)
        PH_WAIT_LOW: if (!pin) phase = PH_WAIT_HIGH;
        PH_WAIT_HIGH: begin
          if (pin) begin
            rise_tick = t;
            phase = PH_WAIT_FALL;
          end
        end
        default: begin
          if (!pin) begin
            val = 32'(t - rise_tick);
            oc = OUT_MEASURED;
            fire = 1'b1;
          end
        end
      endcase
      // a falling edge on the first tick past the deadline still counts as measured
      if (!fire && is_behind(deadline - t)) begin
        if (phase == PH_WAIT_LOW) begin
          val = timeout_ticks;
          oc = OUT_TIMEOUT_NEVER_LOW;
        end else begin
          val = '0;
          oc = OUT_TIMEOUT_AFTER_LOW;
        end
        fire = 1'b1;
      end
      if (fire) begin
        rep.high_time = val;
        rep.outcome = oc;
        reports_due.push_back(rep);
        next_start = t + report_interval;
        phase = PH_IDLE;
      end
    end
    tick_now = t + 1'b1;
  endtask

  always @(posedge clk) begin : watch
    report_t want;
    if (rst) begin
      en = 1'b0;
      timeout_ticks = '0;
      report_interval = '0;
      tick_now = '0;
      next_start = '0;
      deadline = '0;
      rise_tick = '0;
      phase = PH_IDLE;
      reports_due.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready)
        apply_reg_write(reg_idx_t'(paddr[ADDR_WIDTH-1:2]), pwdata);
      if (in_valid && in_ready) capture_tick(pin_level);
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          report_error($sformatf("report beat with none outstanding: %0d outcome %0d",
                                 high_time, outcome));
        end else begin
          want = reports_due.pop_front();
          if (high_time !== want.high_time)
            report_error($sformatf("high_time mismatch: expected %0d, got %0d",
                                   want.high_time, high_time));
          if (outcome !== want.outcome)
            report_error($sformatf("outcome mismatch: expected %0d, got %0d",
                                   want.outcome, outcome));
        end
      end
    end
    pending = reports_due.size();
  end

endmodule

FILE: dv/tb.sv
// bench top for the pwm high-time capture block: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
  import pwmhtc_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [REG_WIDTH-1:0]  pwdata;
  logic [REG_WIDTH-1:0]  prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic                  pin_level;
  logic                  out_valid;
  logic                  out_ready;
  logic [31:0]           high_time;
  logic [1:0]            outcome;

  int errors;
  int pending;
  int beats_sent;   // accepted pin beats, same as the block's tick count
  int squeeze_at;

  pwm_high_time_capture dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .pin_level(pin_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .high_time(high_time), .outcome(outcome)
  );

  pwm_capture_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .pin_level(pin_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .high_time(high_time), .outcome(outcome),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // all reports in, then room for beats still in the pipe
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_pin(input logic lvl, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic lvl, input int n);
    for (int i = 0; i < n; i++) send_pin(lvl, 0);
  endtask

  // square-ish pin with random run lengths, or plain noise
  task automatic run_phase(input int n, input bit noisy, input bit gaps);
    logic lvl;
    int   run;
    lvl = 1'($urandom_range(0, 1));
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        lvl = 1'($urandom_range(0, 1));
      end else if (run == 0) begin
        lvl = ~lvl;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
      end
      if (run > 0) run--;
      send_pin(lvl, gaps ? pick_gap() : 0);
    end
    in_valid <= 1'b0;
  endtask

  // receiver: ready bursts, short and long stalls, one long hold-off
  initial begin : receiver
    int  r;
    bit  squeezed;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && beats_sent >= squeeze_at) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        squeezed = 1'b1;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(50, 150)) @(negedge clk);
        end else if (r < 70) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          n;
    int          random_beats;
    bit          far_start;
    bit          squeezed;
    bit          en;
    logic [31:0] val;
    logic [31:0] ahead;
    logic [31:0] cur_interval;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    pin_level = 1'b0;
    out_ready = 1'b0;
    beats_sent = 0;
    squeeze_at = 32'h7fff_ffff;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // measured pulse, timeout with pin stuck high, timeout after a low
    apb_write(REG_TIMEOUT, 32'd3);
    apb_write(REG_INTERVAL, 32'd0);
    apb_write(REG_FIRST_START, 32'd0);
    apb_write(REG_ENABLE, 32'd1);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 1);
    send_run(1'b1, 5);
    send_run(1'b0, 5);
    in_valid <= 1'b0;
    drain();

    // top of range everywhere: start already passed, window times out as it opens
    apb_write(REG_TIMEOUT, 32'hffff_ffff);
    apb_write(REG_INTERVAL, 32'hffff_ffff);
    apb_write(REG_FIRST_START, 32'hffff_ffff);
    send_pin(1'b1, 0);
    send_pin(1'b0, 0);
    in_valid <= 1'b0;
    drain();

    // falling edge on the tick past the deadline, then parked by a huge interval
    apb_write(REG_TIMEOUT, 32'd1);
    apb_write(REG_INTERVAL, 32'h7fff_ffff);
    apb_write(REG_FIRST_START, 32'd0);
    send_pin(1'b0, 0);
    send_pin(1'b1, 0);
    send_pin(1'b0, 0);
    send_run(1'b1, 2);
    in_valid <= 1'b0;
    drain();

    // zero timeout
    apb_write(REG_TIMEOUT, 32'd0);
    apb_write(REG_INTERVAL, 32'd0);
    apb_write(REG_FIRST_START, beats_sent);
    send_run(1'b1, 2);
    in_valid <= 1'b0;
    drain();

    // disabled with a start far ahead
    apb_write(REG_ENABLE, 32'd0);
    apb_write(REG_FIRST_START, 32'h8000_0000);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    in_valid <= 1'b0;
    drain();

    far_start = 1'b1;
    cur_interval = 32'd0;
    squeezed = 1'b0;
    random_beats = 0;
    while (random_beats < 1400) begin
      if (!squeezed && random_beats >= 600) begin
        // short windows on a noisy pin so reports pile up behind the hold-off
        apb_write(REG_TIMEOUT, 32'd2);
        apb_write(REG_INTERVAL, 32'd0);
        apb_write(REG_FIRST_START, beats_sent);
        apb_write(REG_ENABLE, 32'd1);
        cur_interval = 32'd0;
        far_start = 1'b0;
        squeeze_at = beats_sent + 10;
        run_phase(80, 1'b1, 1'b0);
        random_beats += 80;
        squeezed = 1'b1;
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          r = $urandom_range(0, 19);
          case (r)
            0:       val = 32'd0;
            1:       val = 32'hffff_ffff;
            2:       val = 32'h8000_0000;
            3:       val = 32'h7fff_ffff;
            4:       val = $urandom;
            default: val = $urandom_range(1, 40);
          endcase
          apb_write(REG_TIMEOUT, val);
        end
        if ($urandom_range(0, 9) < 7) begin
          r = $urandom_range(0, 19);
          case (r)
            0:       val = 32'd0;
            1:       val = 32'hffff_ffff;
            2:       val = $urandom;
            default: val = $urandom_range(0, 12);
          endcase
          cur_interval = val;
          apb_write(REG_INTERVAL, val);
        end
        // a parked sequencer always gets a near start tick
        if (far_start || (cur_interval >= 32'h100 && !cur_interval[31])) begin
          val = beats_sent + $urandom_range(0, 20);
          far_start = 1'b0;
          apb_write(REG_FIRST_START, val);
        end else if ($urandom_range(0, 9) < 4) begin
          r = $urandom_range(0, 9);
          case (r)
            0:       val = 32'd0;
            1:       val = 32'hffff_ffff;
            2:       val = $urandom;
            default: val = beats_sent + $urandom_range(0, 20);
          endcase
          ahead = val - beats_sent;
          far_start = (ahead >= 32'h100) && !ahead[31];
          apb_write(REG_FIRST_START, val);
        end
        en = ($urandom_range(0, 9) != 0);
        apb_write(REG_ENABLE, {31'd0, en});
        n = $urandom_range(15, 70);
        run_phase(n, $urandom_range(0, 9) >= 8, $urandom_range(0, 9) >= 3);
        if (en) random_beats += n;
      end
      drain();
    end

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
